// File: src/utf8_stream_decoder_macros.svh
// ----------------------------------------------------------------------------
// UTF-8 stream decoder assertion macros
// Assertion wrappers shared by the decoder modules; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH

`ifndef SYNTHESIS

// Checked at every clock edge outside of reset.
`define USD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define USD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define USD_ASSERT(lbl, clk, rst_n, prop, msg)
`define USD_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// File: src/usd_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder package
// Types and constants shared by the decoder core, result queue and top level.
// ----------------------------------------------------------------------------
package usd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CP_W     = 31;
    localparam int unsigned CNT_W    = 16;
    localparam int unsigned REM_W    = 3;

    // Byte counters saturate at this value.
    localparam logic [CNT_W-1:0] CNT_CAP     = 16'd65535;
    localparam logic [CNT_W-1:0] LIMIT_RESET = 16'd65535;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int unsigned TDATA_OUT_W = 72;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'b001,
        PH_COLLECT = 3'b010,
        PH_STOP    = 3'b100
    } t_phase;

    typedef enum logic [1:0] {
        ST_COMPLETE  = 2'd0,
        ST_BAD_LEAD  = 2'd1,
        ST_MALFORMED = 2'd2,
        ST_LIMIT     = 2'd3
    } t_status;

    typedef enum logic {
        KIND_CHAR    = 1'b0,
        KIND_SUMMARY = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [CP_W-1:0]   code_point;
        t_status           status;
        logic [CNT_W-1:0]  bytes_used;
        logic [CNT_W-1:0]  chars_out;
        logic              last_of_run;
    } t_result;

    // Results produced by one byte, in order; count is 0, 1 or 2.
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

endpackage

// File: src/usd_core.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder core
// Input register, per-buffer decode state and the single-pass byte decoder.
// ----------------------------------------------------------------------------
`include "utf8_stream_decoder_macros.svh"

module usd_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [usd_pkg::BYTE_W-1:0]     i_byte,
    input  logic                           i_last,
    input  logic [usd_pkg::CNT_W-1:0]      i_limit,
    input  logic                           i_room,
    output usd_pkg::t_push                 o_push
);

    logic                          r_in_valid;
    logic [usd_pkg::BYTE_W-1:0]    r_byte;
    logic                          r_last;

    usd_pkg::t_phase               r_phase, n_phase;
    logic [usd_pkg::REM_W-1:0]     r_rem, n_rem;
    logic [usd_pkg::CP_W-1:0]      r_acc, n_acc;
    logic [usd_pkg::CNT_W-1:0]     r_seq, n_seq;
    logic [usd_pkg::CNT_W-1:0]     r_pos, n_pos;
    logic [usd_pkg::CNT_W-1:0]     r_chars, n_chars;
    usd_pkg::t_status              r_status, n_status;

    logic                          w_process;
    logic                          w_emit;
    logic [usd_pkg::CP_W-1:0]      w_cp;
    usd_pkg::t_result              w_char_res;
    usd_pkg::t_result              w_sum_res;

    assign w_process     = r_in_valid && i_room;
    assign s_axis_tready = !r_in_valid || w_process;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_process) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_byte <= i_byte;
            r_last <= i_last;
        end
    end

    always_comb begin
        logic [2:0]                 need;
        logic [usd_pkg::CP_W-1:0]   lead_bits;
        logic [usd_pkg::CP_W-1:0]   acc_sh;
        logic [usd_pkg::REM_W-1:0]  rem_dec;
        logic                       stop;
        usd_pkg::t_status           stop_st;

        need      = 3'd0;
        lead_bits = '0;
        acc_sh    = {r_acc[usd_pkg::CP_W-7:0], r_byte[5:0]};
        rem_dec   = r_rem - 3'd1;
        stop      = 1'b0;
        stop_st   = usd_pkg::ST_COMPLETE;

        n_phase  = r_phase;
        n_rem    = r_rem;
        n_acc    = r_acc;
        n_status = r_status;
        n_seq    = r_seq;
        n_chars  = r_chars;
        w_emit   = 1'b0;
        w_cp     = '0;
        n_pos    = (r_pos < usd_pkg::CNT_CAP) ? r_pos + 16'd1 : r_pos;

        if ((r_byte & 8'hE0) == 8'hC0) begin
            need = 3'd1; lead_bits = {26'd0, r_byte[4:0]};
        end else if ((r_byte & 8'hF0) == 8'hE0) begin
            need = 3'd2; lead_bits = {27'd0, r_byte[3:0]};
        end else if ((r_byte & 8'hF8) == 8'hF0) begin
            need = 3'd3; lead_bits = {28'd0, r_byte[2:0]};
        end else if ((r_byte & 8'hFC) == 8'hF8) begin
            need = 3'd4; lead_bits = {29'd0, r_byte[1:0]};
        end else if ((r_byte & 8'hFE) == 8'hFC) begin
            need = 3'd5; lead_bits = {30'd0, r_byte[0]};
        end

        case (r_phase)
            usd_pkg::PH_IDLE: begin
                if (r_chars >= i_limit) begin
                    stop = 1'b1; stop_st = usd_pkg::ST_LIMIT;
                end else if (!r_byte[7]) begin
                    w_emit = 1'b1;
                    w_cp   = {23'd0, r_byte};
                end else if (need == 3'd0) begin
                    stop = 1'b1; stop_st = usd_pkg::ST_BAD_LEAD;
                end else if (r_last) begin
                    stop = 1'b1; stop_st = usd_pkg::ST_MALFORMED;
                end else begin
                    n_phase = usd_pkg::PH_COLLECT;
                    n_rem   = need;
                    n_acc   = lead_bits;
                end
            end
            usd_pkg::PH_COLLECT: begin
                if (r_byte[7:6] != 2'b10) begin
                    stop = 1'b1; stop_st = usd_pkg::ST_MALFORMED;
                end else if (rem_dec == 3'd0) begin
                    w_emit  = 1'b1;
                    w_cp    = acc_sh;
                    n_phase = usd_pkg::PH_IDLE;
                    n_rem   = '0;
                    n_acc   = '0;
                end else if (r_last) begin
                    stop = 1'b1; stop_st = usd_pkg::ST_MALFORMED;
                end else begin
                    n_rem = rem_dec;
                    n_acc = acc_sh;
                end
            end
            default: begin
            end
        endcase

        if (stop) begin
            n_phase  = usd_pkg::PH_STOP;
            n_status = stop_st;
            n_rem    = '0;
            n_acc    = '0;
        end

        if (w_emit) begin
            n_chars = r_chars + 16'd1;
            n_seq   = n_pos;
        end

        w_char_res.kind        = usd_pkg::KIND_CHAR;
        w_char_res.code_point  = w_cp;
        w_char_res.status      = usd_pkg::ST_COMPLETE;
        w_char_res.bytes_used  = '0;
        w_char_res.chars_out   = '0;
        w_char_res.last_of_run = !r_last;

        w_sum_res.kind        = usd_pkg::KIND_SUMMARY;
        w_sum_res.code_point  = '0;
        w_sum_res.status      = (n_phase == usd_pkg::PH_IDLE) ? usd_pkg::ST_COMPLETE
                                                               : n_status;
        w_sum_res.bytes_used  = n_seq;
        w_sum_res.chars_out   = n_chars;
        w_sum_res.last_of_run = 1'b1;

        if (r_last) begin
            n_phase  = usd_pkg::PH_IDLE;
            n_rem    = '0;
            n_acc    = '0;
            n_seq    = '0;
            n_pos    = '0;
            n_chars  = '0;
            n_status = usd_pkg::ST_COMPLETE;
        end
    end

    always_comb begin
        o_push.count  = w_process ? ({1'b0, w_emit} + {1'b0, r_last}) : 2'd0;
        o_push.first  = w_emit ? w_char_res : w_sum_res;
        o_push.second = w_sum_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= usd_pkg::PH_IDLE;
            r_rem    <= '0;
            r_acc    <= '0;
            r_seq    <= '0;
            r_pos    <= '0;
            r_chars  <= '0;
            r_status <= usd_pkg::ST_COMPLETE;
        end else if (w_process) begin
            r_phase  <= n_phase;
            r_rem    <= n_rem;
            r_acc    <= n_acc;
            r_seq    <= n_seq;
            r_pos    <= n_pos;
            r_chars  <= n_chars;
            r_status <= n_status;
        end
    end

    `USD_ASSERT(a_collect_has_rem, i_clk, i_rst_n,
        (r_phase == usd_pkg::PH_COLLECT) |-> (r_rem != 3'd0), "Collecting with no bytes due")
    `USD_ASSERT(a_last_clears, i_clk, i_rst_n,
        (w_process && r_last) |=> (r_phase == usd_pkg::PH_IDLE && r_chars == 16'd0
            && r_pos == 16'd0), "Buffer state not cleared after last byte")

endmodule

// File: src/usd_out_queue.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder result queue
// Small register queue taking up to two results per cycle, giving one.
// ----------------------------------------------------------------------------
`include "utf8_stream_decoder_macros.svh"

module usd_out_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  usd_pkg::t_push    i_push,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_ready,
    output usd_pkg::t_result  o_head
);

    usd_pkg::t_result               r_mem [usd_pkg::QUEUE_DEPTH];
    logic [usd_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [usd_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [usd_pkg::QCNT_W-1:0]     r_count;
    logic                           w_pop;
    logic [usd_pkg::QPTR_W-1:0]     w_wr_ptr1;

    assign o_valid   = (r_count != '0);
    assign o_head    = r_mem[r_rd_ptr];
    assign w_pop     = o_valid && i_ready;
    assign o_room    = (r_count <= usd_pkg::QCNT_W'(usd_pkg::QUEUE_DEPTH - 2));
    assign w_wr_ptr1 = r_wr_ptr + usd_pkg::QPTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[w_wr_ptr1] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + usd_pkg::QPTR_W'(i_push.count);
            r_rd_ptr <= r_rd_ptr + usd_pkg::QPTR_W'(w_pop);
            r_count  <= r_count + usd_pkg::QCNT_W'(i_push.count)
                        - usd_pkg::QCNT_W'(w_pop);
        end
    end

    `USD_ASSERT(a_no_overflow, i_clk, i_rst_n,
        (i_push.count != 2'd0) |-> ((r_count + usd_pkg::QCNT_W'(i_push.count))
            <= usd_pkg::QCNT_W'(usd_pkg::QUEUE_DEPTH)), "Result queue overflow")
    `USD_ASSERT(a_count_step, i_clk, i_rst_n,
        (w_pop && i_push.count == 2'd0) |=> (r_count == $past(r_count) - 1'b1),
        "Queue count not reduced by a pop")

endmodule

// File: src/utf8_stream_decoder.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder
// Decodes one-to-six-byte UTF-8 sequences from a byte stream into code points.
// ----------------------------------------------------------------------------
// The decoder takes one byte per clock cycle and keeps that rate as long as
// the output side takes one word per cycle; a byte that completes a code point
// on the last byte of a buffer yields two words (code point, then summary), so
// the sustained rate is set by the output port at one word per cycle, buffered
// by a four-word result queue. A byte waits in the input register until the
// queue has room, and its words then enter the queue. The user must write
// the output limit through the configuration channel only while the block is
// idle, which it does not enforce; a new limit governs the next byte decoded.
`include "utf8_stream_decoder_macros.svh"

module utf8_stream_decoder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,  // byte_value
    input  logic                                s_axis_tlast,  // last_byte
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // code_point, status, bytes_used, chars_out, zero fill
    output logic [usd_pkg::TDATA_OUT_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tuser,  // result_kind
    output logic                                m_axis_tlast,  // last_of_run
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [usd_pkg::CNT_W-1:0]           i_cfg_data     // output_limit
);

    logic [usd_pkg::CNT_W-1:0]  r_output_limit;
    logic                       w_room;
    usd_pkg::t_push             w_push;
    usd_pkg::t_result           w_head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_output_limit <= usd_pkg::LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_output_limit <= i_cfg_data;
        end
    end

    usd_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_byte        (s_axis_tdata),
        .i_last        (s_axis_tlast),
        .i_limit       (r_output_limit),
        .i_room        (w_room),
        .o_push        (w_push)
    );

    usd_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (w_room),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_head  (w_head)
    );

    assign m_axis_tdata = {7'd0, w_head.chars_out, w_head.bytes_used,
                           w_head.status, w_head.code_point};
    assign m_axis_tuser = w_head.kind;
    assign m_axis_tlast = w_head.last_of_run;

endmodule

// File: tb/tb_utf8_stream_decoder.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder testbench
// Sends byte buffers through the input stream and predicts every output word
// (decoded code points and end-of-buffer summaries) with a behavioral decoder.
// It covers all sequence lengths, bad leads, bad and missing continuations,
// the output limit, backpressure and random traffic.
// ----------------------------------------------------------------------------
module tb_utf8_stream_decoder;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int MAX_REPORTS    = 10;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [7:0]                      s_axis_tdata = 8'h00;
    logic                            s_axis_tlast = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [usd_pkg::TDATA_OUT_W-1:0] m_axis_tdata;
    logic                            m_axis_tuser;
    logic                            m_axis_tlast;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [usd_pkg::CNT_W-1:0]       i_cfg_data = usd_pkg::LIMIT_RESET;

    // Decoder state mirrored by the predictor.
    usd_pkg::t_phase           dec_phase;
    logic [2:0]                dec_remaining;
    logic [usd_pkg::CP_W-1:0]  dec_acc;
    logic [usd_pkg::CNT_W-1:0] dec_used;
    logic [usd_pkg::CNT_W-1:0] dec_pos;
    logic [usd_pkg::CNT_W-1:0] dec_chars;
    usd_pkg::t_status          dec_stop;
    logic [usd_pkg::CNT_W-1:0] limit_shadow = usd_pkg::LIMIT_RESET;

    usd_pkg::t_result pending_words[$];
    logic [7:0]       frame_bytes[$];
    int unsigned      send_idle_pct = 0;
    int unsigned      recv_stall_pct = 0;
    int               hold_request = 0;
    int               hold_left = 0;
    int               mismatch_count = 0;
    int               stuck_cycles = 0;

    utf8_stream_decoder u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic void clear_buffer_state();
        dec_phase     = usd_pkg::PH_IDLE;
        dec_remaining = '0;
        dec_acc       = '0;
        dec_used      = '0;
        dec_pos       = '0;
        dec_chars     = '0;
        dec_stop      = usd_pkg::ST_COMPLETE;
    endfunction

    function automatic void stop_decoding(usd_pkg::t_status why);
        dec_phase     = usd_pkg::PH_STOP;
        dec_stop      = why;
        dec_remaining = '0;
        dec_acc       = '0;
    endfunction

    // Advances the decoder by one byte and queues the words that byte yields.
    function automatic void decode_byte(logic [7:0] value, logic last);
        logic                     emit;
        logic [usd_pkg::CP_W-1:0] cp;
        logic [2:0]               need;
        usd_pkg::t_result         word;
        emit = 1'b0;
        cp   = '0;
        need = '0;
        if (dec_pos != usd_pkg::CNT_CAP) dec_pos++;
        case (dec_phase)
            usd_pkg::PH_IDLE: begin
                if (dec_chars >= limit_shadow) begin
                    stop_decoding(usd_pkg::ST_LIMIT);
                end else if (!value[7]) begin
                    emit = 1'b1;
                    cp   = {23'd0, value};
                end else begin
                    if (value[7:5] == 3'b110) begin
                        need = 3'd1;
                        dec_acc = {26'd0, value[4:0]};
                    end else if (value[7:4] == 4'b1110) begin
                        need = 3'd2;
                        dec_acc = {27'd0, value[3:0]};
                    end else if (value[7:3] == 5'b11110) begin
                        need = 3'd3;
                        dec_acc = {28'd0, value[2:0]};
                    end else if (value[7:2] == 6'b111110) begin
                        need = 3'd4;
                        dec_acc = {29'd0, value[1:0]};
                    end else if (value[7:1] == 7'b1111110) begin
                        need = 3'd5;
                        dec_acc = {30'd0, value[0]};
                    end
                    if (need == 3'd0) begin
                        stop_decoding(usd_pkg::ST_BAD_LEAD);
                    end else begin
                        dec_phase     = usd_pkg::PH_COLLECT;
                        dec_remaining = need;
                        if (last) stop_decoding(usd_pkg::ST_MALFORMED);
                    end
                end
            end
            usd_pkg::PH_COLLECT: begin
                if (value[7:6] != 2'b10) begin
                    stop_decoding(usd_pkg::ST_MALFORMED);
                end else begin
                    dec_acc       = {dec_acc[usd_pkg::CP_W-7:0], value[5:0]};
                    dec_remaining = dec_remaining - 3'd1;
                    if (dec_remaining == 3'd0) begin
                        emit      = 1'b1;
                        cp        = dec_acc;
                        dec_phase = usd_pkg::PH_IDLE;
                        dec_acc   = '0;
                    end else if (last) begin
                        stop_decoding(usd_pkg::ST_MALFORMED);
                    end
                end
            end
            default: ;
        endcase
        if (emit) begin
            dec_chars = dec_chars + 16'd1;
            dec_used  = dec_pos;
            word = '{kind: usd_pkg::KIND_CHAR, code_point: cp, status: usd_pkg::ST_COMPLETE,
                     bytes_used: '0, chars_out: '0, last_of_run: !last};
            pending_words.push_back(word);
        end
        if (last) begin
            word = '{kind: usd_pkg::KIND_SUMMARY, code_point: '0,
                     status: (dec_phase == usd_pkg::PH_IDLE) ? usd_pkg::ST_COMPLETE
                                                             : dec_stop,
                     bytes_used: dec_used, chars_out: dec_chars, last_of_run: 1'b1};
            pending_words.push_back(word);
            clear_buffer_state();
        end
    endfunction

    function automatic void note_mismatch(string what, logic [63:0] want, logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch in %s: expected %0h, got %0h", what, want, got);
    endfunction

    always @(posedge i_clk) begin : check_words
        usd_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_words.size() == 0) begin
                note_mismatch("unexpected word", '0, m_axis_tdata[63:0]);
            end else begin
                want = pending_words.pop_front();
                if (m_axis_tuser != want.kind)
                    note_mismatch("result kind", want.kind, m_axis_tuser);
                if (m_axis_tdata[30:0] != want.code_point)
                    note_mismatch("code point", want.code_point, m_axis_tdata[30:0]);
                if (m_axis_tdata[32:31] != want.status)
                    note_mismatch("status", want.status, m_axis_tdata[32:31]);
                if (m_axis_tdata[48:33] != want.bytes_used)
                    note_mismatch("bytes used", want.bytes_used, m_axis_tdata[48:33]);
                if (m_axis_tdata[64:49] != want.chars_out)
                    note_mismatch("chars out", want.chars_out, m_axis_tdata[64:49]);
                if (m_axis_tlast != want.last_of_run)
                    note_mismatch("last of run", want.last_of_run, m_axis_tlast);
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] value, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        decode_byte(value, last);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++)
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [usd_pkg::CNT_W-1:0] value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        limit_shadow = value;
    endtask

    // Appends one well-formed sequence of the given length with random payload.
    function automatic void append_char(int len);
        logic [7:0] lead;
        if (len == 1) begin
            frame_bytes.push_back(8'($urandom_range(127)));
        end else begin
            lead = ~(8'hFF >> len) | (8'($urandom) & (8'hFF >> (len + 1)));
            frame_bytes.push_back(lead);
            for (int i = 1; i < len; i++)
                frame_bytes.push_back({2'b10, 6'($urandom)});
        end
    endfunction

    function automatic void make_random_frame();
        int pick;
        int drop;
        frame_bytes.delete();
        for (int c = $urandom_range(1, 5); c > 0; c--) begin
            pick = $urandom_range(9);
            append_char(pick < 4 || pick == 9 ? 1 : pick - 2);
        end
        if ($urandom_range(99) < 20)
            frame_bytes.insert($urandom_range(frame_bytes.size()), 8'($urandom));
        if ($urandom_range(99) < 10) begin
            drop = $urandom_range(1, 3);
            while (drop > 0 && frame_bytes.size() > 1) begin
                void'(frame_bytes.pop_back());
                drop--;
            end
        end
    endfunction

    task automatic test_directed_forms();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // Extremes of the one-, two-, three-, four- and six-byte lengths, up to the 31-bit maximum.
        frame_bytes = '{8'h00, 8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBF, 8'hF7, 8'hBF, 8'hBF,
                        8'hBF, 8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'h7F};
        send_frame();
        // Five-byte sequence, then an invalid lead on the last byte.
        frame_bytes = '{8'hF8, 8'h88, 8'h80, 8'h80, 8'h80, 8'hFF};
        send_frame();
        frame_bytes = '{8'hFE};
        send_frame();
        frame_bytes = '{8'h80};
        send_frame();
        // Truncated sequence, bad continuation, and a lead as the last byte.
        frame_bytes = '{8'hE2, 8'h82};
        send_frame();
        frame_bytes = '{8'hC3, 8'h41};
        send_frame();
        frame_bytes = '{8'hC3};
        send_frame();
    endtask

    task automatic test_output_limit();
        write_limit(16'd1);
        frame_bytes = '{8'h41, 8'h42};
        send_frame();
        frame_bytes = '{8'hC3, 8'hA9};
        send_frame();
        write_limit(16'd2);
        frame_bytes = '{8'h41, 8'hC3, 8'hA9, 8'h42, 8'h43};
        send_frame();
    endtask

    task automatic test_backpressure();
        write_limit(usd_pkg::LIMIT_RESET);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 150;
        frame_bytes.delete();
        repeat (40) append_char(1);
        send_frame();
        // The sender waits for every word before the next buffer.
        wait_drained();
        frame_bytes.delete();
        repeat (4) append_char($urandom_range(1, 6));
        send_frame();
    endtask

    task automatic run_random_frames(int byte_target, int unsigned send_pct,
                                     int unsigned recv_pct);
        int sent;
        sent           = 0;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        while (sent < byte_target) begin
            make_random_frame();
            send_frame();
            sent += frame_bytes.size();
        end
    endtask

    task automatic test_random_traffic();
        write_limit(usd_pkg::LIMIT_RESET);
        run_random_frames(100, 0, 0);
        write_limit(16'd3);
        run_random_frames(100, 74, 0);
        write_limit(16'd1);
        run_random_frames(100, 0, 74);
        write_limit(16'd7);
        run_random_frames(100, 24, 24);
    endtask

    initial begin
        clear_buffer_state();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_forms();
        test_output_limit();
        test_backpressure();
        test_random_traffic();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_words.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
